>>> rtl/gwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwm_pkg
// shared types and constants of the glob wildcard matcher
// ----------------------------------------------------------------------------
package gwm_pkg;

	// wildcard bytes in the pattern
	localparam logic [7:0] STAR_BYTE     = 8'd42;
	localparam logic [7:0] QUESTION_BYTE = 8'd63;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_BEGIN  = 2'd2,
		CMD_TEXT   = 2'd3
	} cmd_t;

	// one input item
	typedef struct packed {
		cmd_t       command;
		logic [7:0] byte_value;
	} cmd_item_t;

	// one result item
	typedef struct packed {
		logic matched;
		logic pattern_full;
	} res_item_t;

	// what travels from one cell to the next with each item
	typedef struct packed {
		logic       vld;
		cmd_t       cmd;
		logic [7:0] data;
		logic       placed;   // append byte already taken by an earlier cell
		logic       row_new;  // row bit of the previous position after this item
		logic       row_old;  // row bit of the previous position before this item
		logic       match;    // row bit at the last used position so far
	} flow_t;

endpackage : gwm_pkg
`default_nettype wire

>>> rtl/glob_wildcard_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glob_wildcard_matcher
// streaming glob matcher for '*' and '?' built as a systolic row of cells
// ----------------------------------------------------------------------------
// The matcher takes one item per clock cycle while cmd_stall is low, and it
// returns one result item per item, in order. Each item walks a chain of a
// head stage and PATTERN_MAX cells, each ending in a register, and passes
// through the whole chain whatever pattern is loaded. Cell j holds pattern
// byte j-1 and row bit j; an item reaching cell j brings the new and old row
// bit of position j-1 from its neighbor, so every cell does one step of the
// recurrence per cycle while the chain advances, and the items are skewed by
// one register per position. A stalled result freezes the whole chain; the
// input side is stalled exactly while the result register holds an item that
// the receiver stalls. Appending to a full pattern drops the byte and flags
// pattern_full on that item's result.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher
	import gwm_pkg::*;
#(
	parameter int PATTERN_MAX = 32
)
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_stall,
	input  wire cmd_item_t cmd_item,
	output logic           res_valid,
	input  wire logic      res_stall,
	output res_item_t      res_item
);

	// chain links: link 0 leaves the head, link PATTERN_MAX is the result register
	flow_t                  chain [PATTERN_MAX+1];
	logic [PATTERN_MAX-1:0] used_vec;
	logic [PATTERN_MAX-1:0] hit_vec;
	logic                   adv;
	flow_t                  last;

	// whole chain moves unless the finished item is held at the output
	assign adv       = !(res_valid && res_stall);
	assign cmd_stall = !adv;

	gwm_head u_head (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.valid  (cmd_valid),
		.item   (cmd_item),
		.dst    (chain[0])
	);

	// one cell per pattern position
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		gwm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.src    (chain[k]),
			.dst    (chain[k+1]),
			.used   (used_vec[k]),
			.hit    (hit_vec[k])
		);
	end

	assign last = chain[PATTERN_MAX];

	// result: the match bit carried from the last used position, and the
	// full flag when no cell took the appended byte
	assign res_valid             = last.vld;
	assign res_item.matched      = last.match;
	assign res_item.pattern_full = (last.cmd == CMD_APPEND) && !last.placed;

`ifndef SYNTHESIS
	// a held result stays put until the receiver takes it
	a_hold_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(res_item)))
		else $error("held result item changed");

	// row bits beyond the pattern stay clear
	a_row_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(hit_vec & ~used_vec) == '0)
		else $error("row bit set outside the loaded pattern");

	// a clear leaves an empty pattern, which the empty text matches
	a_clear_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && last.cmd == CMD_CLEAR) |-> res_item.matched)
		else $error("clear item did not report a match");

	// a dropped append can only happen with every position in use at that time
	a_full_when_all_used: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && chain[PATTERN_MAX-1].vld && chain[PATTERN_MAX-1].cmd == CMD_APPEND
			&& !chain[PATTERN_MAX-1].placed && !used_vec[PATTERN_MAX-1])
		|=> (res_valid && !res_item.pattern_full))
		else $error("append reported full while a position was free");
`endif

endmodule : glob_wildcard_matcher
`default_nettype wire

>>> rtl/gwm_head.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwm_head
// entry stage: holds row bit zero and launches each item into the cell chain
// ----------------------------------------------------------------------------
module gwm_head
	import gwm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      adv,
	input  wire logic      valid,
	input  wire cmd_item_t item,
	output flow_t          dst
);

	logic  bit0_q;
	logic  bit0_d;
	flow_t flow_d;
	flow_t flow_s1;

	always_comb begin
		// a text byte clears bit zero, every other command sets it
		bit0_d         = (item.command != CMD_TEXT);
		flow_d.vld     = valid;
		flow_d.cmd     = item.command;
		flow_d.data    = item.byte_value;
		flow_d.placed  = 1'b0;
		flow_d.row_new = bit0_d;
		flow_d.row_old = bit0_q;
		flow_d.match   = bit0_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit0_q  <= 1'b1;
			flow_s1 <= '0;
		end else if (adv) begin
			flow_s1 <= flow_d;
			if (valid) begin
				bit0_q <= bit0_d;
			end
		end
	end

	assign dst = flow_s1;

endmodule : gwm_head
`default_nettype wire

>>> rtl/gwm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwm_cell
// one pattern position: its byte, its in-use flag and its row bit
// ----------------------------------------------------------------------------
module gwm_cell
	import gwm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  adv,
	input  wire flow_t src,
	output flow_t      dst,
	output logic       used,
	output logic       hit
);

	logic       used_q;
	logic       used_d;
	logic       bit_q;
	logic       bit_d;
	logic [7:0] pat_q;
	logic [7:0] pat_d;
	logic       placed_d;
	logic       star;
	logic       lit_hit;
	flow_t      flow_d;
	flow_t      flow_s1;

	// pattern store update: clear drops the position, append takes the first free one
	always_comb begin
		used_d   = used_q;
		pat_d    = pat_q;
		placed_d = src.placed;
		if (src.cmd == CMD_CLEAR) begin
			used_d = 1'b0;
		end
		if (src.cmd == CMD_APPEND && !used_q && !src.placed) begin
			used_d   = 1'b1;
			pat_d    = src.data;
			placed_d = 1'b1;
		end
	end

	assign star    = (pat_d == STAR_BYTE);
	assign lit_hit = (pat_d == QUESTION_BYTE) || (pat_d == src.data);

	// glob recurrence; non-text commands rebuild the empty-text row
	always_comb begin
		if (src.cmd == CMD_TEXT) begin
			bit_d = used_d && (star ? (src.row_new || bit_q) : (lit_hit && src.row_old));
		end else begin
			bit_d = used_d && star && src.row_new;
		end
	end

	always_comb begin
		flow_d         = src;
		flow_d.placed  = placed_d;
		flow_d.row_new = bit_d;
		flow_d.row_old = bit_q;
		flow_d.match   = used_d ? bit_d : src.match;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 1'b0;
			bit_q   <= 1'b0;
			flow_s1 <= '0;
		end else if (adv) begin
			flow_s1 <= flow_d;
			if (src.vld) begin
				used_q <= used_d;
				bit_q  <= bit_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && src.vld) begin
			pat_q <= pat_d;
		end
	end

	assign dst  = flow_s1;
	assign used = used_q;
	assign hit  = bit_q;

endmodule : gwm_cell
`default_nettype wire
